FILE: src/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and register offsets for the vectored interrupt controller.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int unsigned PadWidth   = 64;
  localparam int unsigned HalfWidth  = 32;
  localparam int unsigned IndexWidth = 6;
  localparam int unsigned GroupSize  = 8;
  localparam int unsigned GroupCount = PadWidth / GroupSize;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  localparam logic [11:0] OFS_SELECT0 = 12'h000;
  localparam logic [11:0] OFS_SELECT1 = 12'h004;
  localparam logic [11:0] OFS_ENSET0  = 12'h030;
  localparam logic [11:0] OFS_ENSET1  = 12'h034;
  localparam logic [11:0] OFS_CLEAR0  = 12'h0B0;
  localparam logic [11:0] OFS_CLEAR1  = 12'h0B4;
  localparam logic [11:0] OFS_VEC0    = 12'h0D0;
  localparam logic [11:0] OFS_VEC1    = 12'h0D4;

  typedef struct packed {
    cmd_e        cmd;
    logic [5:0]  line_index;
    logic        line_level;
    logic [11:0] offset;
    logic [31:0] write_data;
  } vic_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        fiq_out;
  } vic_rsp_t;

endpackage

FILE: src/vic_prio_enc.sv
// ----------------------------------------------------------------------------
// vic_prio_enc
// Lowest-set-bit encoder over 64 bits, split into eight byte groups.
// ----------------------------------------------------------------------------
module vic_prio_enc
  import vic_pkg::*;
(
  input  logic [PadWidth-1:0]   vec_i,
  output logic [IndexWidth-1:0] index_o
);

  logic [GroupCount-1:0] grp_any;
  logic [2:0]            grp_sel;
  logic [GroupSize-1:0]  grp_bits;
  logic [2:0]            bit_sel;

  always_comb begin
    for (int g = 0; g < GroupCount; g++) begin
      grp_any[g] = |vec_i[g*GroupSize +: GroupSize];
    end
  end

  // scan from the top so the lowest set entry wins
  always_comb begin
    grp_sel = 3'd0;
    for (int g = GroupCount - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = 3'(g);
      end
    end
  end

  assign grp_bits = vec_i[grp_sel*GroupSize +: GroupSize];

  always_comb begin
    bit_sel = 3'd0;
    for (int b = GroupSize - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 3'(b);
      end
    end
  end

  assign index_o = {grp_sel, bit_sel};

endmodule

FILE: src/vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_controller
// Interrupt controller with pending, IRQ enable and FIQ select masks.
// ----------------------------------------------------------------------------
//  channel   | ports                  | handshake
//  ----------+------------------------+-----------------------------------
//  request   | start_i, req_i, busy_o | taken when start_i && !busy_o
//  result    | done_o, rsp_o          | one-cycle strobe, cannot stall
//
// A request is registered, processed in the following cycle against the mask
// registers, and its result is then registered and strobed on done_o with rsp_o.
// One request per cycle is sustained; busy_o stays low.
// Reset clears all masks and the pipeline valid flags.
// ----------------------------------------------------------------------------
module vectored_interrupt_controller
  import vic_pkg::*;
#(
  parameter int unsigned SOURCE_COUNT = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  vic_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output vic_rsp_t rsp_o
);

  localparam logic [PadWidth-1:0] ValidMask =
      (SOURCE_COUNT >= PadWidth) ? {PadWidth{1'b1}}
                                 : ((64'd1 << SOURCE_COUNT) - 64'd1);

  vic_req_t req_q;
  logic     req_vld_q;
  vic_rsp_t rsp_q, rsp_d;
  logic     done_q;

  logic [SOURCE_COUNT-1:0] pend_q, pend_d;
  logic [SOURCE_COUNT-1:0] en_q, en_d;
  logic [SOURCE_COUNT-1:0] sel_q, sel_d;

  logic [PadWidth-1:0]   pend_cur, en_cur, sel_cur;
  logic [PadWidth-1:0]   pend_nxt, en_nxt, sel_nxt;
  logic [PadWidth-1:0]   lo_data, hi_data;
  logic [IndexWidth-1:0] vec_index;

  assign busy_o = 1'b0;

  assign pend_cur = PadWidth'(pend_q);
  assign en_cur   = PadWidth'(en_q);
  assign sel_cur  = PadWidth'(sel_q);

  assign lo_data = {{HalfWidth{1'b0}}, req_q.write_data};
  assign hi_data = {req_q.write_data, {HalfWidth{1'b0}}};

  vic_prio_enc u_prio_enc (
    .vec_i   (pend_cur & en_cur),
    .index_o (vec_index)
  );

  always_comb begin
    pend_nxt = pend_cur;
    en_nxt   = en_cur;
    sel_nxt  = sel_cur;
    rsp_d    = '0;
    if (req_vld_q) begin
      case (req_q.cmd)
        CMD_LINE: begin
          if ({1'b0, req_q.line_index} < 7'(SOURCE_COUNT)) begin
            pend_nxt[req_q.line_index] = req_q.line_level;
          end
        end
        CMD_WRITE: begin
          unique case (req_q.offset)
            // keep the upper half and replace the lower half
            OFS_SELECT0: sel_nxt  = ((sel_cur & {{HalfWidth{1'b1}}, {HalfWidth{1'b0}}})
                                    | lo_data) & ValidMask;
            OFS_SELECT1: sel_nxt  = ((sel_cur & {{HalfWidth{1'b0}}, {HalfWidth{1'b1}}})
                                    | hi_data) & ValidMask;
            OFS_ENSET0:  en_nxt   = (en_cur | lo_data) & ValidMask;
            OFS_ENSET1:  en_nxt   = (en_cur | hi_data) & ValidMask;
            OFS_CLEAR0:  pend_nxt = pend_cur & ~lo_data;
            OFS_CLEAR1:  pend_nxt = pend_cur & ~hi_data;
            default: ;
          endcase
        end
        CMD_READ: begin
          if (req_q.offset == OFS_VEC0 || req_q.offset == OFS_VEC1) begin
            rsp_d.read_data = 32'(vec_index);
          end
        end
        default: ;
      endcase
    end
    rsp_d.irq_out = |(pend_nxt & en_nxt);
    rsp_d.fiq_out = |(pend_nxt & sel_nxt);
  end

  assign pend_d = pend_nxt[SOURCE_COUNT-1:0];
  assign en_d   = en_nxt[SOURCE_COUNT-1:0];
  assign sel_d  = sel_nxt[SOURCE_COUNT-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      done_q    <= 1'b0;
      pend_q    <= '0;
      en_q      <= '0;
      sel_q     <= '0;
    end else begin
      req_vld_q <= start_i && !busy_o;
      done_q    <= req_vld_q;
      pend_q    <= pend_d;
      en_q      <= en_d;
      sel_q     <= sel_d;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
